// ----- rtl/tpsc_pkg.sv -----
// shared types, codes and sizes for the texture pixel swizzle converter
package tpsc_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int TILE_BYTES  = 16;
  localparam int TILE_ROWS   = 8;
  localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
  localparam int WORD_AW     = $clog2(STORE_WORDS);
  localparam int ADDR_W      = 20;
  localparam int CFG_DW      = 10;

  typedef enum logic [1:0] {
    CFG_COLOR_FORMAT   = 2'd0,
    CFG_RASTER_WIDTH   = 2'd1,
    CFG_RASTER_HEIGHT  = 2'd2,
    CFG_TEXTURE_LAYOUT = 2'd3
  } tpsc_cfg_idx_t;

  localparam logic [2:0] FMT_565     = 3'd0;
  localparam logic [2:0] FMT_1555    = 3'd1;
  localparam logic [2:0] FMT_4444    = 3'd2;
  localparam logic [2:0] FMT_8888    = 3'd3;
  localparam logic [2:0] FMT_PALETTE = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NOSTORAGE = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [8:0] column;
    logic [8:0] row;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic [7:0] index_in;
  } tpsc_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        red_out;
    logic [7:0]        green_out;
    logic [7:0]        blue_out;
    logic [7:0]        alpha_out;
    logic [7:0]        index_out;
  } tpsc_out_t;

  typedef struct packed {
    logic [2:0] color_format;
    logic [9:0] raster_width;
    logic [9:0] raster_height;
    logic       texture_layout;
  } tpsc_cfg_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] byte_address;
  } tpsc_loc_t;

  typedef struct packed {
    logic               re;
    logic               we;
    logic [3:0]         be;
    logic [WORD_AW-1:0] addr;
    logic [31:0]        wdata;
  } tpsc_mem_req_t;

endpackage

// ----- rtl/texture_pixel_swizzle_converter_core.sv -----
// texture pixel store with format packing, block tiling and read-back widening
// an input transaction reaches out_valid through the address, memory and result registers
// throughput: one transaction per cycle unless out_ready backpressure stalls it, reads and writes mixed freely
// the single-port word memory serves one access per cycle; no pixel hazard arises
// reset: synchronous; config returns to its reset values and a clearing sweep over
// every store word zeroes the store, in_ready stays low until it ends
module texture_pixel_swizzle_converter_core
  import tpsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tpsc_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tpsc_out_t         out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  tpsc_cfg_t     cfg_r;
  logic          a_valid_r;
  tpsc_in_t      a_data_r;
  logic          b_valid_r;
  logic          b_opcode_r;
  logic [2:0]    b_fmt_r;
  tpsc_loc_t     b_loc_r;
  logic          out_valid_r;
  tpsc_out_t     out_data_r;
  tpsc_out_t     out_data_nxt;
  tpsc_loc_t     a_loc;
  tpsc_mem_req_t mem_req;
  logic [31:0]   mem_rdata;
  logic          clearing;
  logic          out_take;
  logic          b_move;
  logic          a_move;
  logic          a_free;
  logic [15:0]   pix16;
  logic [15:0]   rd16;
  logic [7:0]    rd8;
  logic [31:0]   wdata;
  logic [3:0]    be;
  logic          b_free_chk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_format   <= FMT_565;
      cfg_r.raster_width   <= '0;
      cfg_r.raster_height  <= '0;
      cfg_r.texture_layout <= 1'b1;
    end else if (cfg_we) begin
      unique case (tpsc_cfg_idx_t'(cfg_addr))
        CFG_COLOR_FORMAT:   cfg_r.color_format   <= cfg_wdata[2:0];
        CFG_RASTER_WIDTH:   cfg_r.raster_width   <= cfg_wdata[9:0];
        CFG_RASTER_HEIGHT:  cfg_r.raster_height  <= cfg_wdata[9:0];
        CFG_TEXTURE_LAYOUT: cfg_r.texture_layout <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline handshake, backpressure ripples from the output register
  assign out_take = !out_valid_r || out_ready;
  assign b_move   = b_valid_r && out_take;
  assign a_move   = a_valid_r && (!b_valid_r || b_move);
  assign a_free   = !a_valid_r || a_move;
  assign in_ready = a_free && !clearing;

  tpsc_addr u_addr (
    .cfg    (cfg_r),
    .column (a_data_r.column),
    .row    (a_data_r.row),
    .loc    (a_loc)
  );

  // pack the pixel and place it on its byte lanes
  always_comb begin
    unique case (cfg_r.color_format)
      FMT_565:  pix16 = {a_data_r.blue_in[7:3], a_data_r.green_in[7:2],
                         a_data_r.red_in[7:3]};
      FMT_1555: pix16 = {a_data_r.alpha_in[7], a_data_r.blue_in[7:3],
                         a_data_r.green_in[7:3], a_data_r.red_in[7:3]};
      FMT_4444: pix16 = {a_data_r.alpha_in[7:4], a_data_r.blue_in[7:4],
                         a_data_r.green_in[7:4], a_data_r.red_in[7:4]};
      default:  pix16 = '0;
    endcase
    if (cfg_r.color_format == FMT_8888) begin
      wdata = {a_data_r.alpha_in, a_data_r.blue_in, a_data_r.green_in, a_data_r.red_in};
      be    = 4'b1111;
    end else if (cfg_r.color_format == FMT_PALETTE) begin
      wdata = {4{a_data_r.index_in}};
      be    = 4'b0001 << a_loc.byte_address[1:0];
    end else begin
      wdata = {pix16, pix16};
      be    = a_loc.byte_address[1] ? 4'b1100 : 4'b0011;
    end
  end

  assign mem_req.re    = a_move && (a_data_r.opcode == OP_READ);
  assign mem_req.we    = a_move && (a_data_r.opcode == OP_WRITE) && (a_loc.status == ST_OK);
  assign mem_req.be    = be;
  assign mem_req.addr  = a_loc.byte_address[WORD_AW+1:2];
  assign mem_req.wdata = wdata;

  tpsc_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rdata    (mem_rdata),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        a_valid_r <= 1'b1;
      end else if (a_move) begin
        a_valid_r <= 1'b0;
      end
      if (a_move) begin
        b_valid_r <= 1'b1;
      end else if (b_move) begin
        b_valid_r <= 1'b0;
      end
      if (b_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_data_r <= in_data;
    end
    if (a_move) begin
      b_opcode_r <= a_data_r.opcode;
      b_fmt_r    <= cfg_r.color_format;
      b_loc_r    <= a_loc;
    end
    if (b_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  // read data stays in the memory output register until the next read issues
  assign rd16 = b_loc_r.byte_address[1] ? mem_rdata[31:16] : mem_rdata[15:0];
  assign rd8  = 8'(mem_rdata >> {b_loc_r.byte_address[1:0], 3'b000});

  always_comb begin
    out_data_nxt              = '0;
    out_data_nxt.status       = b_loc_r.status;
    if (b_loc_r.status == ST_OK) begin
      out_data_nxt.byte_address = b_loc_r.byte_address;
      if (b_opcode_r == OP_READ) begin
        unique case (b_fmt_r)
          FMT_565: begin
            out_data_nxt.red_out   = widen5(rd16[4:0]);
            out_data_nxt.green_out = widen6(rd16[10:5]);
            out_data_nxt.blue_out  = widen5(rd16[15:11]);
            out_data_nxt.alpha_out = 8'hFF;
          end
          FMT_1555: begin
            out_data_nxt.red_out   = widen5(rd16[4:0]);
            out_data_nxt.green_out = widen5(rd16[9:5]);
            out_data_nxt.blue_out  = widen5(rd16[14:10]);
            out_data_nxt.alpha_out = {8{rd16[15]}};
          end
          FMT_4444: begin
            out_data_nxt.red_out   = widen4(rd16[3:0]);
            out_data_nxt.green_out = widen4(rd16[7:4]);
            out_data_nxt.blue_out  = widen4(rd16[11:8]);
            out_data_nxt.alpha_out = widen4(rd16[15:12]);
          end
          FMT_8888: begin
            out_data_nxt.red_out   = mem_rdata[7:0];
            out_data_nxt.green_out = mem_rdata[15:8];
            out_data_nxt.blue_out  = mem_rdata[23:16];
            out_data_nxt.alpha_out = mem_rdata[31:24];
          end
          FMT_PALETTE: out_data_nxt.index_out = rd8;
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b_free_chk = !b_valid_r || b_move;

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !(in_valid && in_ready))
    else $error("transaction accepted during store clear");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> a_valid_r && a_loc.status == ST_OK && b_free_chk)
    else $error("store write without a valid in-range write");

  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("read and write issued in one cycle");

  a_bad_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_OK |-> out_data_r.byte_address == '0)
    else $error("address reported on a failed transaction");

  a_out_follows_b: assert property (@(posedge clk) disable iff (!rst_n)
    b_move |=> out_valid_r)
    else $error("result lost between memory stage and output");

endmodule

// ----- rtl/tpsc_addr.sv -----
// range check and linear or tiled byte address of one pixel
module tpsc_addr
  import tpsc_pkg::*;
(
  input  tpsc_cfg_t  cfg,
  input  logic [8:0] column,
  input  logic [8:0] row,
  output tpsc_loc_t  loc
);

  logic [1:0]  bpp_shift;
  logic        no_storage;
  logic        out_of_range;
  logic [11:0] stride;
  logic [10:0] xbyte;
  logic [20:0] lin_addr;
  logic [13:0] blk_row_off;
  logic [14:0] blk;
  logic [21:0] tile_addr;
  logic        tiled;

  always_comb begin
    bpp_shift  = 2'd1;
    no_storage = 1'b0;
    priority if (cfg.color_format == FMT_8888) begin
      bpp_shift = 2'd2;
    end else if (cfg.color_format == FMT_PALETTE) begin
      bpp_shift = 2'd0;
    end else if (cfg.color_format == FMT_565 || cfg.color_format == FMT_1555 ||
                 cfg.color_format == FMT_4444) begin
      bpp_shift = 2'd1;
    end else begin
      no_storage = 1'b1;
    end
    if (cfg.raster_width == 10'd0 || cfg.raster_height == 10'd0 ||
        cfg.raster_width > 10'(MAX_WIDTH) || cfg.raster_height > 10'(MAX_HEIGHT)) begin
      no_storage = 1'b1;
    end
  end

  assign out_of_range = ({1'b0, column} >= cfg.raster_width) ||
                        ({1'b0, row} >= cfg.raster_height);

  assign stride = {2'b00, cfg.raster_width} << bpp_shift;
  assign xbyte  = {2'b00, column} << bpp_shift;

  assign lin_addr = 21'(row) * 21'(stride) + 21'(xbyte);

  // block layout: 16-byte by 8-row blocks, blocks ordered along the row first
  assign blk_row_off = row[8:3] * stride[11:4];
  assign blk         = 15'(xbyte[10:4]) + 15'(blk_row_off);
  assign tile_addr   = {blk, row[2:0], xbyte[3:0]};

  assign tiled = cfg.texture_layout && (stride[3:0] == 4'd0) &&
                 (cfg.raster_height[2:0] == 3'd0);

  always_comb begin
    loc.status       = ST_OK;
    loc.byte_address = '0;
    priority if (no_storage) begin
      loc.status = ST_NOSTORAGE;
    end else if (out_of_range) begin
      loc.status = ST_RANGE;
    end else if (tiled) begin
      loc.byte_address = tile_addr[ADDR_W-1:0];
    end else begin
      loc.byte_address = lin_addr[ADDR_W-1:0];
    end
  end

endmodule

// ----- rtl/tpsc_store.sv -----
// pixel store: 32-bit words with byte enables, cleared by a sweep after reset
module tpsc_store
  import tpsc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  tpsc_mem_req_t req,
  output logic [31:0]   rdata,
  output logic          clearing
);

  logic [3:0][7:0]    mem [STORE_WORDS];
  logic [31:0]        rdata_r;
  logic               clr_busy_r;
  logic [WORD_AW-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == WORD_AW'(STORE_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.we) begin
      for (int i = 0; i < 4; i++) begin
        if (req.be[i]) begin
          mem[req.addr][i] <= req.wdata[8*i +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata    = rdata_r;
  assign clearing = clr_busy_r;

endmodule

// ----- test/tpsc_checker.sv -----
// scoreboard for the texture pixel converter: texel store model, prediction and result compare
module tpsc_checker
  import tpsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  tpsc_in_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  tpsc_out_t         out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int unsigned       fail_count,
  output int unsigned       pending,
  output int unsigned       matched_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_BYTES = MAX_WIDTH * MAX_HEIGHT * 4;

  logic [7:0]  texel_mem [int unsigned];
  tpsc_cfg_t   raster_cfg;
  tpsc_out_t   texel_q [$];
  int unsigned mism = 0;
  int unsigned matched = 0;

  // bytes never written read as zero, the store is cleared at reset
  function automatic logic [7:0] peek(int unsigned a);
    if (a < STORE_BYTES && texel_mem.exists(a)) return texel_mem[a];
    return 8'h00;
  endfunction

  function automatic void poke(int unsigned a, logic [7:0] v);
    if (a < STORE_BYTES) texel_mem[a] = v;
  endfunction

  function automatic logic [7:0] widen4(logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] widen5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic tpsc_out_t predict_texel(tpsc_in_t px);
    tpsc_out_t   res;
    int unsigned bpp;
    int unsigned stride;
    int unsigned xb;
    int unsigned blk;
    int unsigned addr;
    logic [15:0] hw;
    bit          tiled;
    res = '0;
    case (raster_cfg.color_format)
      FMT_565, FMT_1555, FMT_4444: bpp = 2;
      FMT_8888:                    bpp = 4;
      FMT_PALETTE:                 bpp = 1;
      default:                     bpp = 0;
    endcase
    if (bpp == 0 || raster_cfg.raster_width == 0 || raster_cfg.raster_height == 0 ||
        raster_cfg.raster_width > MAX_WIDTH || raster_cfg.raster_height > MAX_HEIGHT) begin
      res.status = ST_NOSTORAGE;
      return res;
    end
    if (px.column >= raster_cfg.raster_width || px.row >= raster_cfg.raster_height) begin
      res.status = ST_RANGE;
      return res;
    end
    stride = raster_cfg.raster_width * bpp;
    xb     = px.column * bpp;
    tiled  = raster_cfg.texture_layout && (stride % TILE_BYTES) == 0 &&
             (raster_cfg.raster_height % TILE_ROWS) == 0;
    if (tiled) begin
      blk  = xb / TILE_BYTES + (px.row / TILE_ROWS) * (stride / TILE_BYTES);
      addr = blk * TILE_BYTES * TILE_ROWS + (px.row % TILE_ROWS) * TILE_BYTES +
             xb % TILE_BYTES;
    end else begin
      addr = px.row * stride + xb;
    end
    res.status       = ST_OK;
    res.byte_address = ADDR_W'(addr);

    if (px.opcode == OP_WRITE) begin
      case (raster_cfg.color_format)
        FMT_565:  hw = {px.blue_in[7:3], px.green_in[7:2], px.red_in[7:3]};
        FMT_1555: hw = {px.alpha_in[7], px.blue_in[7:3], px.green_in[7:3], px.red_in[7:3]};
        FMT_4444: hw = {px.alpha_in[7:4], px.blue_in[7:4], px.green_in[7:4], px.red_in[7:4]};
        default:  hw = '0;
      endcase
      if (raster_cfg.color_format == FMT_8888) begin
        poke(addr, px.red_in);
        poke(addr + 1, px.green_in);
        poke(addr + 2, px.blue_in);
        poke(addr + 3, px.alpha_in);
      end else if (raster_cfg.color_format == FMT_PALETTE) begin
        poke(addr, px.index_in);
      end else begin
        poke(addr, hw[7:0]);
        poke(addr + 1, hw[15:8]);
      end
      return res;
    end

    if (raster_cfg.color_format == FMT_PALETTE) begin
      res.index_out = peek(addr);
    end else if (raster_cfg.color_format == FMT_8888) begin
      res.red_out   = peek(addr);
      res.green_out = peek(addr + 1);
      res.blue_out  = peek(addr + 2);
      res.alpha_out = peek(addr + 3);
    end else begin
      hw = {peek(addr + 1), peek(addr)};
      case (raster_cfg.color_format)
        FMT_565: begin
          res.red_out   = widen5(hw[4:0]);
          res.green_out = widen6(hw[10:5]);
          res.blue_out  = widen5(hw[15:11]);
          res.alpha_out = 8'hFF;
        end
        FMT_1555: begin
          res.red_out   = widen5(hw[4:0]);
          res.green_out = widen5(hw[9:5]);
          res.blue_out  = widen5(hw[14:10]);
          res.alpha_out = hw[15] ? 8'hFF : 8'h00;
        end
        default: begin
          res.red_out   = widen4(hw[3:0]);
          res.green_out = widen4(hw[7:4]);
          res.blue_out  = widen4(hw[11:8]);
          res.alpha_out = widen4(hw[15:12]);
        end
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    tpsc_out_t want;
    if (!rst_n) begin
      texel_q.delete();
      texel_mem.delete();
      raster_cfg.color_format   = FMT_565;
      raster_cfg.raster_width   = '0;
      raster_cfg.raster_height  = '0;
      raster_cfg.texture_layout = 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        if (texel_q.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("%0t: result with nothing outstanding: st %0d addr %05h", $realtime,
                     out_data.status, out_data.byte_address);
        end else begin
          want = texel_q.pop_front();
          if (out_data.status !== want.status || out_data.byte_address !== want.byte_address ||
              out_data.red_out !== want.red_out || out_data.green_out !== want.green_out ||
              out_data.blue_out !== want.blue_out || out_data.alpha_out !== want.alpha_out ||
              out_data.index_out !== want.index_out) begin
            mism++;
            if (mism <= 10) begin
              $display("%0t: mismatch, expected st %0d addr %05h rgba %02h %02h %02h %02h idx %02h",
                       $realtime, want.status, want.byte_address, want.red_out,
                       want.green_out, want.blue_out, want.alpha_out, want.index_out);
              $display("                 actual st %0d addr %05h rgba %02h %02h %02h %02h idx %02h",
                       out_data.status, out_data.byte_address, out_data.red_out,
                       out_data.green_out, out_data.blue_out, out_data.alpha_out,
                       out_data.index_out);
            end
          end else begin
            matched++;
          end
        end
      end
      if (in_valid && in_ready) texel_q.push_back(predict_texel(in_data));
      if (cfg_we) begin
        case (cfg_addr)
          CFG_COLOR_FORMAT:   raster_cfg.color_format   = cfg_wdata[2:0];
          CFG_RASTER_WIDTH:   raster_cfg.raster_width   = cfg_wdata[9:0];
          CFG_RASTER_HEIGHT:  raster_cfg.raster_height  = cfg_wdata[9:0];
          CFG_TEXTURE_LAYOUT: raster_cfg.texture_layout = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    fail_count    <= mism;
    pending       <= texel_q.size();
    matched_count <= matched;
  end

endmodule

// ----- test/testbench.sv -----
// top of the texture pixel converter bench: clock, reset, pixel traffic and verdict
module testbench;
  import tpsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 96;
  localparam logic [2:0]  FMT_UNDEF_LO  = 3'd5;
  localparam logic [2:0]  FMT_UNDEF_HI  = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  tpsc_in_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  tpsc_out_t         out_data;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned matched_count;
  int unsigned sent = 0;
  int unsigned reads = 0;
  int unsigned settings = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;

  texture_pixel_swizzle_converter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  tpsc_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .matched_count (matched_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("FAIL");
    $finish;
  end

  function automatic bit idle_roll();
    return !steady && ($urandom_range(0, 99) < 19);
  endfunction

  // receiver backpressure
  always @(posedge clk) out_ready <= !idle_roll();

  function automatic tpsc_in_t pixel(logic op, int col, int row, logic [7:0] r, logic [7:0] g,
                                     logic [7:0] b, logic [7:0] a, logic [7:0] idx);
    tpsc_in_t px;
    px.opcode   = op;
    px.column   = col[8:0];
    px.row      = row[8:0];
    px.red_in   = r;
    px.green_in = g;
    px.blue_in  = b;
    px.alpha_in = a;
    px.index_in = idx;
    return px;
  endfunction

  // channel values lean toward the ends and the 1555 alpha threshold
  function automatic logic [7:0] channel_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 8'h00;
    if (roll < 30) return 8'hFF;
    if (roll < 35) return 8'h7F;
    if (roll < 40) return 8'h80;
    return 8'($urandom);
  endfunction

  function automatic int unsigned raster_extent();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6)  return 0;
    if (roll < 12) return $urandom_range(MAX_WIDTH + 1, 1023);
    if (roll < 35) begin
      case ($urandom_range(0, 3))
        0:       return 1;
        1:       return 8;
        2:       return 16;
        default: return 512;
      endcase
    end
    if (roll < 65) return 8 * $urandom_range(1, 64);
    return $urandom_range(1, 64);
  endfunction

  function automatic int unsigned coord_in(int unsigned extent);
    if (extent == 0 || extent > 512) return $urandom_range(0, 511);
    return $urandom_range(0, extent - 1);
  endfunction

  task automatic push_pixel(tpsc_in_t px);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (px.opcode == OP_READ) reads++;
  endtask

  // let every outstanding result arrive, then cover the pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_raster(logic [2:0] fmt, int unsigned w, int unsigned h, logic lay);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_COLOR_FORMAT;
    cfg_wdata <= CFG_DW'(fmt);
    @(posedge clk);
    cfg_addr  <= CFG_RASTER_WIDTH;
    cfg_wdata <= CFG_DW'(w);
    @(posedge clk);
    cfg_addr  <= CFG_RASTER_HEIGHT;
    cfg_wdata <= CFG_DW'(h);
    @(posedge clk);
    cfg_addr  <= CFG_TEXTURE_LAYOUT;
    cfg_wdata <= CFG_DW'(lay);
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // mostly writes and read-backs of written pixels, some raw noise for the range checks
  task automatic run_mix(int unsigned count, int unsigned w, int unsigned h);
    tpsc_in_t    written [$];
    tpsc_in_t    px;
    logic [63:0] raw;
    int unsigned roll;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        raw = {$urandom, $urandom};
        px  = raw[$bits(tpsc_in_t)-1:0];
      end else if (roll < 55) begin
        px = pixel(OP_WRITE, coord_in(w), coord_in(h), channel_value(), channel_value(),
                   channel_value(), channel_value(), channel_value());
        written.push_back(px);
        if (written.size() > 64) void'(written.pop_front());
      end else begin
        px = pixel(OP_READ, coord_in(w), coord_in(h), channel_value(), channel_value(),
                   channel_value(), channel_value(), channel_value());
        if (written.size() != 0 && $urandom_range(0, 3) != 0) begin
          raw       = 64'(written[$urandom_range(0, written.size() - 1)]);
          px.column = raw[$bits(tpsc_in_t)-2 -: 9];
          px.row    = raw[$bits(tpsc_in_t)-11 -: 9];
        end
      end
      push_pixel(px);
    end
  endtask

  initial begin
    logic [2:0]  fmt;
    int unsigned w;
    int unsigned h;
    logic        lay;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // store clearing sweep
    while (!in_ready) @(posedge clk);

    // reset raster has no storage
    push_pixel(pixel(OP_WRITE, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_pixel(pixel(OP_READ, 511, 511, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    settle();
    program_raster(FMT_565, 512, 512, 1'b1);
    push_pixel(pixel(OP_WRITE, 511, 511, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_pixel(pixel(OP_READ, 511, 511, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_pixel(pixel(OP_WRITE, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_pixel(pixel(OP_READ, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

    // alpha on both sides of the 1555 threshold, then both coordinate limits
    settle();
    program_raster(FMT_1555, 8, 8, 1'b1);
    push_pixel(pixel(OP_WRITE, 3, 5, 8'hC8, 8'h64, 8'h3A, 8'h80, 8'h11));
    push_pixel(pixel(OP_WRITE, 4, 5, 8'h17, 8'hE9, 8'h9C, 8'h7F, 8'h22));
    push_pixel(pixel(OP_READ, 3, 5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_pixel(pixel(OP_READ, 4, 5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_pixel(pixel(OP_WRITE, 8, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_pixel(pixel(OP_READ, 0, 8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    // unaligned stride falls back to linear
    settle();
    program_raster(FMT_4444, 5, 3, 1'b1);
    push_pixel(pixel(OP_WRITE, 4, 2, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h99));
    push_pixel(pixel(OP_READ, 4, 2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    settle();
    program_raster(FMT_8888, 4, 8, 1'b0);
    push_pixel(pixel(OP_WRITE, 3, 7, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A));
    push_pixel(pixel(OP_READ, 3, 7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    settle();
    program_raster(FMT_PALETTE, 16, 8, 1'b1);
    push_pixel(pixel(OP_WRITE, 15, 7, 8'h5C, 8'hC5, 8'h0F, 8'hF0, 8'hFF));
    push_pixel(pixel(OP_READ, 15, 7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00));

    // undefined format codes and an oversized raster have no storage
    settle();
    program_raster(FMT_UNDEF_LO, 8, 8, 1'b1);
    push_pixel(pixel(OP_READ, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();
    program_raster(FMT_UNDEF_HI, 8, 8, 1'b1);
    push_pixel(pixel(OP_WRITE, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    settle();
    program_raster(FMT_565, 1023, 1023, 1'b0);
    push_pixel(pixel(OP_READ, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      steady <= (p == 6);
      case (p)
        0: begin
          fmt = FMT_8888;
          w   = 512;
          h   = 512;
          lay = 1'b1;
        end
        1: begin
          fmt = FMT_PALETTE;
          w   = 512;
          h   = 512;
          lay = 1'b0;
        end
        default: begin
          if ($urandom_range(0, 99) < 8) fmt = 3'($urandom_range(FMT_UNDEF_LO, FMT_UNDEF_HI));
          else fmt = 3'($urandom_range(FMT_565, FMT_PALETTE));
          w   = raster_extent();
          h   = raster_extent();
          lay = 1'($urandom);
        end
      endcase
      program_raster(fmt, w, h, lay);
      run_mix(PHASE_ITEMS, w, h);
    end
    settle();

    $display("ran %0d pixel transactions (%0d reads) under %0d register settings",
             sent, reads, settings);
    $display("%0d results matched the predicted texel data, %0d mismatches",
             matched_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
